@@ hw/rtl/gha_pkg.sv @@
// Shared types, constants and a helper function of the generational handle allocator.
`default_nettype none

package gha_pkg;

	localparam int unsigned CAPACITY_DEF = 1024;
	localparam int unsigned GEN_W        = 32;
	localparam int unsigned PORT_IDX_W   = 10;
	localparam int unsigned PORT_CNT_W   = 11;

	typedef enum logic [1:0] {
		CMD_CREATE  = 2'd0,
		CMD_DESTROY = 2'd1,
		CMD_QUERY   = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_DEAD = 2'd1,
		STS_FULL = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t                  command;
		logic [PORT_IDX_W-1:0] entity_index;
		logic [GEN_W-1:0]      entity_generation;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [PORT_IDX_W-1:0] handle_index;
		logic [GEN_W-1:0]      handle_generation;
		logic [PORT_CNT_W-1:0] live_count;
	} rsp_t;

	// Advances a generation by one, wrapping past the all-ones value to one.
	function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
		logic [GEN_W-1:0] n;
		n = g + GEN_W'(1);
		return (n == '0) ? GEN_W'(1) : n;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gha_stream_if.sv @@
// Valid/ready stream interface carrying one payload per transfer.
`default_nettype none

interface gha_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gha_ram.sv @@
// Simple dual-port synchronous RAM with one write port and one registered read port.
`default_nettype none

module gha_ram #(
	parameter int unsigned DEPTH = gha_pkg::CAPACITY_DEF,
	parameter int unsigned WIDTH = gha_pkg::GEN_W,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/generational_handle_allocator.sv @@
// Generational handle allocator: slot table and free-index stack held in synchronous RAMs.
// Create, destroy and query each do one RAM read on the accepting edge, then evaluation and
// write-back; the registered read ports of the slot and stack RAMs set this split.
// Clear walks one slot per cycle over every used slot, then finishes like the other commands.
// The result register lets the next command be accepted while a result waits to be taken.
// Reset (arst_n low) empties the allocator at once; the RAMs need no clearing pass.
`default_nettype none

module generational_handle_allocator #(
	parameter int unsigned CAPACITY = gha_pkg::CAPACITY_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	gha_stream_if.sink   cmd,
	gha_stream_if.source rsp
);

	import gha_pkg::*;

	localparam int unsigned IDX_W  = $clog2(CAPACITY);
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W  = (CNT_W > PORT_IDX_W) ? CNT_W : PORT_IDX_W;
	localparam int unsigned SLOT_W = 1 + GEN_W;
	localparam int unsigned STK_W  = IDX_W + GEN_W;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_WALK = 3'b100
	} state_t;

	// Control state.
	state_t           state_q;
	logic [CNT_W-1:0] free_depth_q;
	logic [CNT_W-1:0] slots_used_q;
	logic [CNT_W-1:0] live_q;
	logic [CNT_W-1:0] walk_q;
	logic             walk_vld_s1;
	logic [IDX_W-1:0] walk_idx_s1;
	logic             rsp_valid_q;

	// Payload registers.
	req_t req_q;
	rsp_t rsp_q;

	// RAM ports.
	logic              slot_we, slot_re;
	logic [IDX_W-1:0]  slot_wa, slot_ra;
	logic [SLOT_W-1:0] slot_wd, slot_rd;
	logic              stk_we, stk_re;
	logic [IDX_W-1:0]  stk_wa, stk_ra;
	logic [STK_W-1:0]  stk_wd, stk_rd;

	// Datapath.
	logic             in_xfer, out_free, exec_fire, walk_busy;
	logic             slot_alive, in_range, handle_live;
	logic [GEN_W-1:0] slot_gen, gen_adv, walk_gen;
	logic [IDX_W-1:0] stk_idx;
	logic [GEN_W-1:0] stk_gen;
	logic [IDX_W-1:0] new_slot;
	logic [GEN_W-1:0] new_gen;
	logic [CNT_W-1:0] free_nx, used_nx, live_nx;
	rsp_t             res;

	// A command transfers only when the engine is idle; the result register decouples the
	// two sides, so an outstanding result does not hold back the next command.
	assign cmd.ready = (state_q == S_IDLE);
	assign in_xfer   = cmd.valid && cmd.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign exec_fire = (state_q == S_EXEC) && out_free;
	assign walk_busy = (walk_q != slots_used_q);

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Each slot entry is {alive, generation}. Entries at or above slots_used have not been
	// written since reset and are treated as dead with generation zero, so slots_used acts as a fill
	// count and those entries are never read for a decision.
	gha_ram #(.DEPTH(CAPACITY), .WIDTH(SLOT_W)) u_slot_ram (
		.clk     (clk),
		.wr_en   (slot_we),
		.wr_addr (slot_wa),
		.wr_data (slot_wd),
		.rd_en   (slot_re),
		.rd_addr (slot_ra),
		.rd_data (slot_rd)
	);

	// Each free-stack entry is {index, generation}. The generation of a freed slot cannot
	// change while it is dead, so keeping it beside the index lets a create finish from a
	// single stack read, without a second read of the slot table.
	gha_ram #(.DEPTH(CAPACITY), .WIDTH(STK_W)) u_stack_ram (
		.clk     (clk),
		.wr_en   (stk_we),
		.wr_addr (stk_wa),
		.wr_data (stk_wd),
		.rd_en   (stk_re),
		.rd_addr (stk_ra),
		.rd_data (stk_rd)
	);

	// Reads are launched on the transfer edge from the incoming index and the stack top, so the data
	// is ready in the execute cycle. The read data registers hold while the result stalls,
	// as no further read is issued until the next transfer.
	assign slot_re = in_xfer || ((state_q == S_WALK) && walk_busy);
	assign slot_ra = (state_q == S_WALK) ? walk_q[IDX_W-1:0]
	                                     : IDX_W'(cmd.data.entity_index);
	assign stk_re  = in_xfer;
	assign stk_ra  = IDX_W'(free_depth_q - CNT_W'(1));

	assign slot_alive = slot_rd[GEN_W];
	assign slot_gen   = slot_rd[GEN_W-1:0];
	assign stk_idx    = stk_rd[STK_W-1:GEN_W];
	assign stk_gen    = stk_rd[GEN_W-1:0];
	assign gen_adv    = next_gen(slot_gen);
	assign walk_gen   = slot_alive ? gen_adv : slot_gen;

	// A handle is live only for a slot that has been handed out at some point, is alive now
	// and still carries the same generation.
	assign in_range    = CMP_W'(req_q.entity_index) < CMP_W'(slots_used_q);
	assign handle_live = in_range && slot_alive && (slot_gen == req_q.entity_generation);

	always_comb begin
		slot_we  = 1'b0;
		slot_wa  = '0;
		slot_wd  = '0;
		stk_we   = 1'b0;
		stk_wa   = '0;
		stk_wd   = '0;
		new_slot = '0;
		new_gen  = '0;
		free_nx  = free_depth_q;
		used_nx  = slots_used_q;
		live_nx  = live_q;
		res      = '0;
		res.status = STS_OK;

		case (req_q.command)
			CMD_CREATE: begin
				// Reuse the most recently freed slot first; otherwise open a fresh one.
				if (free_depth_q != '0) begin
					new_slot = stk_idx;
					new_gen  = stk_gen;
					free_nx  = free_depth_q - CNT_W'(1);
				end else if (slots_used_q != CAP_CNT) begin
					new_slot = slots_used_q[IDX_W-1:0];
					new_gen  = '0;
					used_nx  = slots_used_q + CNT_W'(1);
				end
				if ((free_depth_q != '0) || (slots_used_q != CAP_CNT)) begin
					slot_we  = exec_fire;
					slot_wa  = new_slot;
					slot_wd  = {1'b1, new_gen};
					live_nx  = live_q + CNT_W'(1);
					res.handle_index      = PORT_IDX_W'(new_slot);
					res.handle_generation = new_gen;
				end else begin
					res.status = STS_FULL;
				end
			end
			CMD_DESTROY: begin
				// Kill the slot, move its generation on so that stale handles fail,
				// and push it with its new generation.
				if (handle_live && (free_depth_q != CAP_CNT)) begin
					slot_we = exec_fire;
					slot_wa = IDX_W'(req_q.entity_index);
					slot_wd = {1'b0, gen_adv};
					stk_we  = exec_fire;
					stk_wa  = free_depth_q[IDX_W-1:0];
					stk_wd  = {IDX_W'(req_q.entity_index), gen_adv};
					free_nx = free_depth_q + CNT_W'(1);
					live_nx = live_q - CNT_W'(1);
				end else begin
					res.status = STS_DEAD;
				end
			end
			CMD_QUERY: begin
				res.status = handle_live ? STS_OK : STS_DEAD;
			end
			CMD_CLEAR: begin
				// The walk has already rebuilt the stack as 0 .. slots_used-1.
				free_nx = slots_used_q;
				live_nx = '0;
			end
			default: begin
				res.status = STS_OK;
			end
		endcase

		// During a clear, each slot read in the previous cycle is written back dead, with its
		// generation moved on if it was alive, and its index goes to the same stack place.
		if ((state_q == S_WALK) && walk_vld_s1) begin
			slot_we = 1'b1;
			slot_wa = walk_idx_s1;
			slot_wd = {1'b0, walk_gen};
			stk_we  = 1'b1;
			stk_wa  = walk_idx_s1;
			stk_wd  = {walk_idx_s1, walk_gen};
		end

		res.live_count = PORT_CNT_W'(live_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_depth_q <= '0;
			slots_used_q <= '0;
			live_q       <= '0;
			walk_q       <= '0;
			walk_vld_s1  <= 1'b0;
			walk_idx_s1  <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (cmd.data.command == CMD_CLEAR) begin
							state_q     <= S_WALK;
							walk_q      <= '0;
							walk_vld_s1 <= 1'b0;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_WALK: begin
					if (walk_busy) begin
						walk_q      <= walk_q + CNT_W'(1);
						walk_vld_s1 <= 1'b1;
						walk_idx_s1 <= walk_q[IDX_W-1:0];
					end else begin
						walk_vld_s1 <= 1'b0;
						if (!walk_vld_s1) begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					if (exec_fire) begin
						state_q      <= S_IDLE;
						free_depth_q <= free_nx;
						slots_used_q <= used_nx;
						live_q       <= live_nx;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (exec_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q <= cmd.data;
		end
		if (exec_fire) begin
			rsp_q <= res;
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/generational_handle_allocator_tb.sv @@
// Self-checking testbench for the generational handle allocator.
`timescale 1ns / 1ps

// Tracks slot liveness, generations and the free-index stack, and holds the replies due.
class handle_ledger;
	bit                          alive [gha_pkg::CAPACITY_DEF];
	bit [gha_pkg::GEN_W-1:0]     gen_of [gha_pkg::CAPACITY_DEF];
	bit [gha_pkg::PORT_IDX_W-1:0] free_list [gha_pkg::CAPACITY_DEF];
	int unsigned free_top;
	int unsigned used_slots;
	int unsigned live_handles;
	gha_pkg::rsp_t pending_replies [$];
	int unsigned mismatches;
	int unsigned n_created, n_refused, n_destroyed, n_rejected;
	int unsigned n_live_hits, n_dead_hits, n_clears, peak_live;

	function new();
		for (int i = 0; i < gha_pkg::CAPACITY_DEF; i++) begin
			alive[i]  = 1'b0;
			gen_of[i] = '0;
		end
		free_top     = 0;
		used_slots   = 0;
		live_handles = 0;
		mismatches   = 0;
		n_created = 0; n_refused = 0; n_destroyed = 0; n_rejected = 0;
		n_live_hits = 0; n_dead_hits = 0; n_clears = 0; peak_live = 0;
	endfunction

	function bit [gha_pkg::GEN_W-1:0] bumped(input bit [gha_pkg::GEN_W-1:0] g);
		return (g == {gha_pkg::GEN_W{1'b1}}) ? gha_pkg::GEN_W'(1) : g + gha_pkg::GEN_W'(1);
	endfunction

	function bit holds(input int unsigned idx, input bit [gha_pkg::GEN_W-1:0] g);
		return idx < used_slots && alive[idx] && gen_of[idx] == g;
	endfunction

	function bit full();
		return free_top == 0 && used_slots == gha_pkg::CAPACITY_DEF;
	endfunction

	// Applies one accepted command and queues the reply it must produce.
	function void note_command(input gha_pkg::req_t r);
		gha_pkg::rsp_t e;
		int unsigned slot;
		bit granted;
		e = '0;
		e.status = gha_pkg::STS_OK;
		granted = 1'b0;
		slot = 0;
		case (r.command)
			gha_pkg::CMD_CREATE: begin
				if (free_top > 0) begin
					free_top--;
					slot = free_list[free_top];
					granted = 1'b1;
				end else if (used_slots < gha_pkg::CAPACITY_DEF) begin
					slot = used_slots;
					used_slots++;
					granted = 1'b1;
				end
				if (granted) begin
					alive[slot] = 1'b1;
					live_handles++;
					e.handle_index      = slot[gha_pkg::PORT_IDX_W-1:0];
					e.handle_generation = gen_of[slot];
					n_created++;
				end else begin
					e.status = gha_pkg::STS_FULL;
					n_refused++;
				end
			end
			gha_pkg::CMD_DESTROY: begin
				if (holds(r.entity_index, r.entity_generation)
						&& free_top < gha_pkg::CAPACITY_DEF) begin
					alive[r.entity_index]  = 1'b0;
					gen_of[r.entity_index] = bumped(gen_of[r.entity_index]);
					free_list[free_top]    = r.entity_index;
					free_top++;
					if (live_handles > 0)
						live_handles--;
					n_destroyed++;
				end else begin
					e.status = gha_pkg::STS_DEAD;
					n_rejected++;
				end
			end
			gha_pkg::CMD_QUERY: begin
				if (holds(r.entity_index, r.entity_generation)) begin
					n_live_hits++;
				end else begin
					e.status = gha_pkg::STS_DEAD;
					n_dead_hits++;
				end
			end
			default: begin
				for (int i = 0; i < used_slots; i++) begin
					if (alive[i])
						gen_of[i] = bumped(gen_of[i]);
					alive[i]     = 1'b0;
					free_list[i] = i[gha_pkg::PORT_IDX_W-1:0];
				end
				free_top     = used_slots;
				live_handles = 0;
				n_clears++;
			end
		endcase
		if (live_handles > peak_live)
			peak_live = live_handles;
		e.live_count = live_handles[gha_pkg::PORT_CNT_W-1:0];
		pending_replies = {pending_replies, e};
	endfunction

	function void compare_field(input string what, input longint unsigned want,
			input longint unsigned seen);
		if (want != seen) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, seen);
			mismatches++;
		end
	endfunction

	// Compares one accepted reply with the oldest one due.
	function void check_reply(input gha_pkg::rsp_t got);
		gha_pkg::rsp_t want;
		if (pending_replies.size() == 0) begin
			$display("%0t: unexpected reply: expected none, actual %0h", $time, got);
			mismatches++;
		end else begin
			want = pending_replies.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("handle_index", want.handle_index, got.handle_index);
			compare_field("handle_generation", want.handle_generation, got.handle_generation);
			compare_field("live_count", want.live_count, got.live_count);
		end
	endfunction
endclass

module generational_handle_allocator_tb;
	import gha_pkg::*;

	// Generous bound on the run, as a full-table clear walks every one of its slots.
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned IDLE_PCT    = 31;

	logic clk;
	logic arst_n;

	gha_stream_if #(.payload_t(req_t)) cmd_if ();
	gha_stream_if #(.payload_t(rsp_t)) rsp_if ();

	generational_handle_allocator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	handle_ledger ledger;
	// While set, neither side inserts gaps or stalls.
	bit           steady_flow;
	int unsigned  sent_total;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Reset is applied once, at the start, and never again.
	initial begin
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// The run is abandoned if it has not ended well within this many cycles.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic bit take_a_break();
		return !steady_flow && ($urandom_range(99) < IDLE_PCT);
	endfunction

	// Result side: ready is redrawn at every rising edge. Both valid and ready are looked at
	// on the falling edge, where nothing moves, and the transfer is then counted at the
	// following rising edge.
	initial begin : reply_side
		bit            fired;
		gha_pkg::rsp_t seen;
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		rsp_if.ready <= !take_a_break();
		forever begin
			@(negedge clk);
			fired = rsp_if.valid && rsp_if.ready;
			seen  = rsp_if.data;
			@(posedge clk);
			if (fired)
				ledger.check_reply(seen);
			rsp_if.ready <= !take_a_break();
		end
	end

	// Presents one command, with a random gap first, and returns at the edge on which
	// the transfer took place. Valid is left high, so the next call either keeps it
	// high with new data or lowers it for a gap.
	task automatic send_command(input req_t r);
		bit taken;
		while (take_a_break()) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.data  <= r;
		do begin
			@(negedge clk);
			taken = cmd_if.ready;
			@(posedge clk);
		end while (!taken);
		ledger.note_command(r);
		sent_total++;
	endtask

	task automatic issue(input cmd_t c, input int unsigned idx, input logic [GEN_W-1:0] g);
		req_t r;
		r.command           = c;
		r.entity_index      = idx[PORT_IDX_W-1:0];
		r.entity_generation = g;
		send_command(r);
	endtask

	// Holds the command side quiet until every reply due has been taken.
	task automatic drain_replies();
		cmd_if.valid <= 1'b0;
		while (ledger.pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// Builds a destroy or a query. Most carry a handle that is live right now, some a
	// handle of a used slot with its current, previous or next generation, some an
	// arbitrary index with a small generation, and the rest arbitrary bits.
	function automatic req_t handle_request(input cmd_t c);
		req_t        r;
		int unsigned roll;
		int unsigned start;
		int unsigned idx;
		bit          found;
		r.command           = c;
		r.entity_index      = PORT_IDX_W'($urandom_range(1023));
		r.entity_generation = $urandom();
		roll  = $urandom_range(99);
		found = 1'b0;
		if (roll < 70 && ledger.live_handles > 0) begin
			start = $urandom_range(ledger.used_slots - 1);
			for (int k = 0; k < ledger.used_slots && !found; k++) begin
				idx = (start + k) % ledger.used_slots;
				if (ledger.alive[idx])
					found = 1'b1;
			end
			r.entity_index      = PORT_IDX_W'(idx);
			r.entity_generation = ledger.gen_of[idx];
		end else if (roll < 85 && ledger.used_slots > 0) begin
			idx = $urandom_range(ledger.used_slots - 1);
			r.entity_index = PORT_IDX_W'(idx);
			case ($urandom_range(2))
				0:       r.entity_generation = ledger.gen_of[idx];
				1:       r.entity_generation = ledger.gen_of[idx] - 1;
				default: r.entity_generation = ledger.gen_of[idx] + 1;
			endcase
		end else if (roll < 92) begin
			// Small generations, so that chance matches against young slots occur.
			r.entity_generation = GEN_W'($urandom_range(3));
		end
		return r;
	endfunction

	// A random command with the given share of creates; clears are kept rare because
	// each one walks every used slot.
	function automatic req_t mixed_request(input int unsigned create_pct);
		req_t        r;
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < create_pct) begin
			r.command           = CMD_CREATE;
			r.entity_index      = PORT_IDX_W'($urandom_range(1023));
			r.entity_generation = $urandom();
		end else if (roll < 97) begin
			r = handle_request(($urandom_range(99) < 55) ? CMD_DESTROY : CMD_QUERY);
		end else begin
			r.command           = CMD_CLEAR;
			r.entity_index      = PORT_IDX_W'($urandom_range(1023));
			r.entity_generation = $urandom();
		end
		return r;
	endfunction

	task automatic random_burst(input int unsigned count, input int unsigned create_pct);
		repeat (count)
			send_command(mixed_request(create_pct));
	endtask

	initial begin : command_side
		ledger      = new();
		steady_flow = 1'b0;
		sent_total  = 0;
		cmd_if.valid <= 1'b0;
		cmd_if.data  <= '0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Directed opening on an empty table: handles that cannot be live yet, and a
		// clear with no slot ever used.
		issue(CMD_QUERY, 0, 0);
		issue(CMD_DESTROY, 0, 0);
		issue(CMD_CLEAR, 0, 0);
		// Fresh slots are taken in order with generation zero.
		issue(CMD_CREATE, 0, 0);
		issue(CMD_CREATE, 1023, 32'hFFFF_FFFF);
		issue(CMD_CREATE, 0, 0);
		issue(CMD_QUERY, 0, 0);
		issue(CMD_QUERY, 1, 1);
		// Destroying a live handle advances its generation; the old handle is then stale.
		issue(CMD_DESTROY, 1, 0);
		issue(CMD_DESTROY, 1, 0);
		issue(CMD_QUERY, 1, 0);
		// The new generation alone does not make a freed slot live.
		issue(CMD_QUERY, 1, 1);
		// A freed index is reused before any new slot is taken.
		issue(CMD_CREATE, 0, 0);
		issue(CMD_QUERY, 1, 1);
		// Indices past the high-water mark are never live, nor is a used slot with the wrong generation.
		issue(CMD_QUERY, 1023, 32'hFFFF_FFFF);
		issue(CMD_DESTROY, 1023, 32'hFFFF_FFFF);
		issue(CMD_QUERY, 2, 32'hFFFF_FFFF);
		issue(CMD_DESTROY, 0, 0);
		// Clear advances only the slots still alive and restacks every used index, so
		// the following creates pop the highest indices first.
		issue(CMD_CLEAR, 0, 0);
		issue(CMD_CREATE, 0, 0);
		issue(CMD_CREATE, 0, 0);
		issue(CMD_QUERY, 2, 1);
		issue(CMD_CLEAR, 1023, 32'hFFFF_FFFF);
		issue(CMD_QUERY, 10'h155, 32'hAAAA_AAAA);
		issue(CMD_QUERY, 10'h2AA, 32'h5555_5555);

		// The sender waits here until every outstanding reply has been returned.
		drain_replies();

		// A long stretch with no gaps and no stalls on either side.
		steady_flow = 1'b1;
		random_burst(80, 40);
		steady_flow = 1'b0;
		drain_replies();

		random_burst(15, 35);

		// Fill the table to capacity, then keep asking so that creates are refused, and follow
		// with a mixed burst of commands starting at the full mark.
		while (!ledger.full())
			send_command(mixed_request(100));
		repeat (6)
			send_command(mixed_request(100));
		random_burst(30, 60);
		issue(CMD_CLEAR, $urandom_range(1023), $urandom());

		random_burst(10, 45);

		// All stimulus is in; wait for the last replies, then watch for strays.
		drain_replies();
		repeat (40) @(posedge clk);

		$display("Sent %0d commands: %0d creates granted, %0d refused at capacity, %0d clears.",
			sent_total, ledger.n_created, ledger.n_refused, ledger.n_clears);
		$display("Destroys %0d accepted / %0d rejected, queries %0d live / %0d dead, peak %0d live.",
			ledger.n_destroyed, ledger.n_rejected, ledger.n_live_hits, ledger.n_dead_hits,
			ledger.peak_live);
		if (ledger.mismatches == 0 && ledger.pending_replies.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
